@@ rtl/utf8_stream_decoder_unit_assert.svh @@
// Assertion macros for the UTF-8 stream decoder.
// Used by the top level; it expects i_clk and i_rst_n in scope.
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTF8SD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/utf8sd_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by the decoder, the result queue, the top level and the testbench.
package utf8sd_pkg;

    localparam int CP_W       = 21;
    localparam int FOLLOW_W   = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // One decoded result: a code point or an error.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            err;
    } t_res;

    // All results caused by one input byte (one or two).
    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_pair;

    // Status of the result queue seen by the top level.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             sub;
        logic             full;
    } t_fifo_stat;

    // Status of the decoder state seen by the top level.
    typedef struct packed {
        logic [FOLLOW_W-1:0] follow;
    } t_dec_stat;

endpackage

@@ rtl/utf8sd_in_if.sv @@
// Input channel of the UTF-8 stream decoder: one byte per transaction.
// Depends on nothing.
interface utf8sd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       final_byte;

    modport source (output valid, output byte_value, output final_byte, input ready);
    modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

@@ rtl/utf8sd_out_if.sv @@
// Output channel of the UTF-8 stream decoder: one result per transaction.
// Depends on nothing.
interface utf8sd_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        is_error;
    logic        last_of_run;

    modport source (output valid, output code_point, output is_error,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input is_error,
                    input last_of_run, output ready);
endinterface

@@ rtl/utf8sd_decode.sv @@
// Decoder state registers and the per-byte update logic.
// Depends on utf8sd_pkg.
module utf8sd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_final,
    output logic              o_push,
    output utf8sd_pkg::t_pair o_pair,
    output utf8sd_pkg::t_dec_stat o_stat
);
    import utf8sd_pkg::*;

    // Result of handling a byte with no open sequence.
    typedef struct packed {
        logic                emit;
        t_res                res;
        logic [FOLLOW_W-1:0] follow;
        logic [CP_W-1:0]     partial;
    } t_idle;

    // Results collected so far for the current byte.
    typedef struct packed {
        logic v0;
        logic v1;
        t_res r0;
        t_res r1;
    } t_acc;

    function automatic t_res err_res();
        t_res r;
        r.cp  = '0;
        r.err = 1'b1;
        return r;
    endfunction

    function automatic t_acc add_res(input t_acc a, input t_res r);
        t_acc q;
        q = a;
        if (!a.v0) begin
            q.v0 = 1'b1;
            q.r0 = r;
        end else begin
            q.v1 = 1'b1;
            q.r1 = r;
        end
        return q;
    endfunction

    function automatic t_idle idle_byte(input logic [7:0] b);
        t_idle q;
        q = '0;
        priority if (!b[7]) begin
            q.emit   = 1'b1;
            q.res.cp = {{(CP_W-8){1'b0}}, b};
        end else if (!b[6]) begin
            q.emit = 1'b1;
            q.res  = err_res();
        end else if (!b[5]) begin
            q.partial = {{(CP_W-5){1'b0}}, b[4:0]};
            q.follow  = FOLLOW_W'(1);
        end else if (!b[4]) begin
            q.partial = {{(CP_W-4){1'b0}}, b[3:0]};
            q.follow  = FOLLOW_W'(2);
        end else if (!b[3]) begin
            q.partial = {{(CP_W-3){1'b0}}, b[2:0]};
            q.follow  = FOLLOW_W'(3);
        end else begin
            q.emit = 1'b1;
            q.res  = err_res();
        end
        return q;
    endfunction

    logic [FOLLOW_W-1:0] r_follow;
    logic [CP_W-1:0]     r_partial;
    logic [FOLLOW_W-1:0] n_follow;
    logic [CP_W-1:0]     n_partial;
    t_acc                acc;
    t_idle               idl;
    t_res                done_res;

    // Next state and results for the byte on the input.
    always_comb begin
        acc       = '0;
        n_follow  = r_follow;
        n_partial = r_partial;
        idl       = idle_byte(i_byte);
        done_res  = '0;
        if (r_follow == '0) begin
            // No open sequence.
            if (idl.emit) begin
                acc = add_res(acc, idl.res);
            end
            n_follow  = idl.follow;
            n_partial = idl.partial;
        end else if (!i_byte[7]) begin
            // ASCII byte inside a sequence is consumed as an error.
            acc       = add_res(acc, err_res());
            n_follow  = '0;
            n_partial = '0;
        end else if (!i_byte[6]) begin
            // Follow byte shifts six payload bits in.
            n_partial = {r_partial[CP_W-7:0], i_byte[5:0]};
            n_follow  = r_follow - FOLLOW_W'(1);
            if (n_follow == '0) begin
                done_res.cp  = n_partial;
                done_res.err = 1'b0;
                acc          = add_res(acc, done_res);
                n_partial    = '0;
            end
        end else begin
            // A start byte drops the open sequence with an error and is then decoded afresh.
            acc = add_res(acc, err_res());
            if (idl.emit) begin
                acc = add_res(acc, idl.res);
            end
            n_follow  = idl.follow;
            n_partial = idl.partial;
        end
        // A sequence still open at the end of the string is truncated.
        if (i_final) begin
            if (n_follow != '0) begin
                acc = add_res(acc, err_res());
            end
            n_follow  = '0;
            n_partial = '0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_follow  <= '0;
            r_partial <= '0;
        end else if (i_accept) begin
            r_follow  <= n_follow;
            r_partial <= n_partial;
        end
    end

    assign o_push        = i_accept && acc.v0;
    assign o_pair.two    = acc.v1;
    assign o_pair.r0     = acc.r0;
    assign o_pair.r1     = acc.r1;
    assign o_stat.follow = r_follow;
endmodule

@@ rtl/utf8sd_res_fifo.sv @@
// Result queue: holds the one or two results of each byte and sends them
// out one per transaction. Depends on utf8sd_pkg and utf8sd_out_if.
module utf8sd_res_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  utf8sd_pkg::t_pair      i_pair,
    output utf8sd_pkg::t_fifo_stat o_stat,
    utf8sd_out_if.source           o_out
);
    import utf8sd_pkg::*;

    t_pair            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             r_sub;
    t_pair            head;
    t_res             head_res;
    logic             out_xfer;
    logic             pop;

    assign head     = r_mem[r_rd_ptr];
    assign head_res = r_sub ? head.r1 : head.r0;
    assign out_xfer = o_out.valid && o_out.ready;
    assign pop      = out_xfer && (r_sub || !head.two);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

    // Pointers, fill count and the index of the result within the head entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
                r_sub    <= 1'b0;
            end else if (out_xfer) begin
                r_sub <= 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(pop);
        end
    end

    assign o_out.valid       = (r_count != '0);
    assign o_out.code_point  = head_res.cp;
    assign o_out.is_error    = head_res.err;
    assign o_out.last_of_run = r_sub || !head.two;

    assign o_stat.count = r_count;
    assign o_stat.sub   = r_sub;
    assign o_stat.full  = (r_count == CNT_W'(FIFO_DEPTH));
endmodule

@@ rtl/utf8_stream_decoder_unit.sv @@
// UTF-8 stream decoder: one byte in per transaction, code points or errors out.
// A byte's results are written into the result queue as it is accepted and offered from there in order.
// Throughput: one byte per cycle while the result queue is not full; a byte that
// causes two results sends them out one at a time from a four-entry result queue.
// Reset: synchronous, active low; clears the decoder state and empties the queue.
// Depends on utf8sd_pkg, utf8sd_in_if, utf8sd_out_if, utf8sd_decode, utf8sd_res_fifo.
module utf8_stream_decoder_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    utf8sd_in_if.sink    i_in,
    utf8sd_out_if.source o_out
);
    import utf8sd_pkg::*;

    `include "utf8_stream_decoder_unit_assert.svh"

    logic       accept;
    logic       push;
    t_pair      pair;
    t_dec_stat  dec_stat;
    t_fifo_stat fifo_stat;

    // A byte is taken whenever the queue has room for its entry.
    assign i_in.ready = !fifo_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    utf8sd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.byte_value),
        .i_final  (i_in.final_byte),
        .o_push   (push),
        .o_pair   (pair),
        .o_stat   (dec_stat)
    );

    utf8sd_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (pair),
        .o_stat  (fifo_stat),
        .o_out   (o_out)
    );

    // Checks on the decoder and queue bookkeeping.
    `UTF8SD_ASSERT_NEXT(a_final_idle, accept && i_in.final_byte, dec_stat.follow == '0, "state open after final byte")
    `UTF8SD_ASSERT_SAME(a_valid_count, 1'b1, o_out.valid == (fifo_stat.count != '0), "valid disagrees with fill count")
    `UTF8SD_ASSERT_SAME(a_sub_valid, fifo_stat.sub, o_out.valid, "second result pending with empty queue")
    `UTF8SD_ASSERT_NEXT(a_pop_count, o_out.valid && o_out.ready && o_out.last_of_run && !push, fifo_stat.count == $past(fifo_stat.count) - CNT_W'(1), "fill count not lowered on pop")
endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for utf8_stream_decoder_unit: directed and random byte streams.
// Depends on utf8sd_pkg, utf8sd_in_if, utf8sd_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
    import utf8sd_pkg::*;

    // Traffic phases: who idles, and how often.
    typedef enum int {
        PH_FREE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } t_phase;

    // One byte waiting to be sent, with the phase it belongs to.
    typedef struct {
        logic [7:0] b;
        logic       fin;
        bit         drain;
        t_phase     phase;
    } t_byte_item;

    // One decoded result as seen on the output channel.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            err;
        logic            last;
    } t_cp_result;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    utf8sd_in_if  in_ch ();
    utf8sd_out_if out_ch ();

    utf8_stream_decoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_byte_item pending_bytes[$];
    t_cp_result expected_code_points[$];
    t_cp_result observed_code_points[$];

    // Decoder state as the testbench predicts it.
    logic [FOLLOW_W-1:0] follow_due = '0;
    logic [CP_W-1:0]     acc_value  = '0;

    t_phase cur_phase    = PH_FREE;
    int     n_errors     = 0;
    int     bytes_sent   = 0;
    int     results_seen = 0;
    int     error_results = 0;
    int     stall_cycles = 0;

    // Clock generation.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit roll_idle(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic t_cp_result mk_result(logic [CP_W-1:0] cp, logic err);
        t_cp_result r;
        r.cp   = cp;
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

    // Handles a byte that arrives with no sequence open.
    function automatic void start_or_single(logic [7:0] b, ref t_cp_result res[$]);
        if (!b[7]) begin
            res.push_back(mk_result({13'd0, b}, 1'b0));
        end else if (!b[6]) begin
            res.push_back(mk_result('0, 1'b1));
        end else if (!b[5]) begin
            acc_value  = {16'd0, b[4:0]};
            follow_due = 2'd1;
        end else if (!b[4]) begin
            acc_value  = {17'd0, b[3:0]};
            follow_due = 2'd2;
        end else if (!b[3]) begin
            acc_value  = {18'd0, b[2:0]};
            follow_due = 2'd3;
        end else begin
            res.push_back(mk_result('0, 1'b1));
        end
    endfunction

    // Works out the results that one accepted byte causes and queues them.
    function automatic void predict_code_points(logic [7:0] b, logic fin);
        t_cp_result res[$];
        if (follow_due == 0) begin
            start_or_single(b, res);
        end else if (!b[7]) begin
            // ASCII inside a sequence drops it.
            res.push_back(mk_result('0, 1'b1));
            follow_due = '0;
            acc_value  = '0;
        end else if (!b[6]) begin
            acc_value  = {acc_value[CP_W-7:0], b[5:0]};
            follow_due = follow_due - 2'd1;
            if (follow_due == 0) begin
                res.push_back(mk_result(acc_value, 1'b0));
                acc_value = '0;
            end
        end else begin
            // A start byte inside a sequence: error, then a fresh start.
            res.push_back(mk_result('0, 1'b1));
            follow_due = '0;
            acc_value  = '0;
            start_or_single(b, res);
        end
        if (fin) begin
            if (follow_due != 0) begin
                res.push_back(mk_result('0, 1'b1));
            end
            follow_due = '0;
            acc_value  = '0;
        end
        if (res.size() > 0) begin
            res[res.size()-1].last = 1'b1;
        end
        foreach (res[i]) begin
            expected_code_points.push_back(res[i]);
        end
    endfunction

    task automatic queue_byte(logic [7:0] b, logic fin, t_phase ph, bit drain = 1'b0);
        t_byte_item it;
        it.b     = b;
        it.fin   = fin;
        it.drain = drain;
        it.phase = ph;
        pending_bytes.push_back(it);
    endtask

    function automatic logic [7:0] lead_byte(int len);
        logic [31:0] r;
        r = $urandom;
        case (len)
            1: return {1'b0, r[6:0]};
            2: return {3'b110, r[4:0]};
            3: return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    // Mostly well-formed sequences, plus truncated ones and raw noise bytes.
    task automatic add_random_phase(t_phase ph, int n_items);
        int          added;
        int          kind;
        int          len;
        int          keep;
        bit          first;
        logic [7:0]  b;
        logic        fin;
        logic [31:0] r;
        added = 0;
        first = 1'b1;
        while (added < n_items) begin
            kind = $urandom_range(99, 0);
            if (kind < 88) begin
                len = $urandom_range(4, 1);
                keep = len;
                if (kind >= 78) begin
                    len = $urandom_range(4, 2);
                    keep = $urandom_range(len - 1, 1);
                end
                for (int i = 0; i < keep; i++) begin
                    r = $urandom;
                    b = (i == 0) ? lead_byte(len) : {2'b10, r[5:0]};
                    fin = (i == keep - 1) && ($urandom_range(7, 0) == 0);
                    queue_byte(b, fin, ph, first);
                    first = 1'b0;
                    added++;
                end
            end else begin
                r = $urandom;
                queue_byte(r[7:0], $urandom_range(3, 0) == 0, ph, first);
                first = 1'b0;
                added++;
            end
        end
    endtask

    // Driver: presents the queued bytes and predicts each accepted one.
    always @(posedge i_clk) begin
        t_byte_item nxt;
        bit         give;
        int         idle_pct;
        if (!i_rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.byte_value <= 8'h00;
            in_ch.final_byte <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_code_points(in_ch.byte_value, in_ch.final_byte);
                bytes_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                give = 1'b0;
                if (pending_bytes.size() > 0) begin
                    nxt = pending_bytes[0];
                    cur_phase <= nxt.phase;
                    idle_pct = (nxt.phase == PH_SRC_IDLE) ? 69 :
                               (nxt.phase == PH_BOTH) ? 21 : 0;
                    if (nxt.drain && expected_code_points.size() > 0) begin
                        give = 1'b0;
                    end else begin
                        give = !roll_idle(idle_pct);
                    end
                end
                if (give) begin
                    void'(pending_bytes.pop_front());
                    in_ch.valid      <= 1'b1;
                    in_ch.byte_value <= nxt.b;
                    in_ch.final_byte <= nxt.fin;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and capture of each result transaction.
    always @(posedge i_clk) begin
        int stall_pct;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                observed_code_points.push_back({out_ch.code_point, out_ch.is_error,
                                                out_ch.last_of_run});
            end
            stall_pct = (cur_phase == PH_SNK_STALL) ? 69 :
                        (cur_phase == PH_BOTH) ? 21 : 0;
            out_ch.ready <= !roll_idle(stall_pct);
        end
    end

    // Checker: compares each observed result with the oldest expectation.
    always @(negedge i_clk) begin
        t_cp_result got;
        t_cp_result want;
        if (observed_code_points.size() > 0) begin
            got = observed_code_points.pop_front();
            results_seen++;
            if (got.err) begin
                error_results++;
            end
            if (expected_code_points.size() == 0) begin
                $display("%0t: unexpected result cp=%h err=%b last=%b",
                         $time, got.cp, got.err, got.last);
                n_errors++;
            end else begin
                want = expected_code_points.pop_front();
                if (got.cp !== want.cp) begin
                    $display("%0t: code_point mismatch: expected %h actual %h",
                             $time, want.cp, got.cp);
                    n_errors++;
                end
                if (got.err !== want.err) begin
                    $display("%0t: is_error mismatch: expected %b actual %b",
                             $time, want.err, got.err);
                    n_errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last_of_run mismatch: expected %b actual %b",
                             $time, want.last, got.last);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog counter: cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        // Directed part: ASCII extremes, every sequence length, and the error cases.
        queue_byte(8'h00, 1'b0, PH_FREE);
        queue_byte(8'h7F, 1'b1, PH_FREE);
        queue_byte(8'hC2, 1'b0, PH_FREE);
        queue_byte(8'hA9, 1'b0, PH_FREE);
        queue_byte(8'hE2, 1'b0, PH_FREE);
        queue_byte(8'h82, 1'b0, PH_FREE);
        queue_byte(8'hAC, 1'b0, PH_FREE);
        // Four-byte sequence giving the largest code point.
        queue_byte(8'hF7, 1'b0, PH_FREE);
        queue_byte(8'hBF, 1'b0, PH_FREE);
        queue_byte(8'hBF, 1'b0, PH_FREE);
        queue_byte(8'hBF, 1'b0, PH_FREE);
        // Invalid lead bytes and lone follow bytes.
        queue_byte(8'hF8, 1'b0, PH_FREE);
        queue_byte(8'hFF, 1'b0, PH_FREE);
        queue_byte(8'h80, 1'b0, PH_FREE);
        queue_byte(8'hBF, 1'b0, PH_FREE);
        // ASCII inside a sequence.
        queue_byte(8'hE2, 1'b0, PH_FREE);
        queue_byte(8'h41, 1'b0, PH_FREE);
        // Start inside a sequence, then the new sequence completes.
        queue_byte(8'hC3, 1'b0, PH_FREE);
        queue_byte(8'hC2, 1'b0, PH_FREE);
        queue_byte(8'hA9, 1'b0, PH_FREE);
        // Start inside a sequence with an invalid lead: two errors.
        queue_byte(8'hC3, 1'b0, PH_FREE);
        queue_byte(8'hFF, 1'b0, PH_FREE);
        // Truncated at the final byte.
        queue_byte(8'hE2, 1'b0, PH_FREE);
        queue_byte(8'h82, 1'b1, PH_FREE);
        // Start inside a sequence on the final byte: two errors.
        queue_byte(8'hC3, 1'b0, PH_FREE);
        queue_byte(8'hE2, 1'b1, PH_FREE);

        add_random_phase(PH_FREE, 140);
        add_random_phase(PH_SRC_IDLE, 140);
        add_random_phase(PH_SNK_STALL, 140);
        add_random_phase(PH_BOTH, 140);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || in_ch.valid) begin
            @(posedge i_clk);
        end
        while (expected_code_points.size() > 0 || observed_code_points.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        @(posedge i_clk);

        if (expected_code_points.size() > 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, expected_code_points.size());
            n_errors++;
        end
        $display("Sent %0d bytes over four traffic phases; checked %0d results, %0d of them errors.",
                 bytes_sent, results_seen, error_results);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ utf8_stream_decoder_unit.f @@
+incdir+rtl
rtl/utf8sd_pkg.sv
rtl/utf8sd_in_if.sv
rtl/utf8sd_out_if.sv
rtl/utf8sd_decode.sv
rtl/utf8sd_res_fifo.sv
rtl/utf8_stream_decoder_unit.sv
verif/tb_top.sv
